// ===== rtl/note_line_parser_core_defines.svh =====
// ----------------------------------------------------------------------------
// note line parser assertion macros
// shared property forms for the parser checks
// ----------------------------------------------------------------------------
`ifndef NOTE_LINE_PARSER_CORE_DEFINES_SVH
`define NOTE_LINE_PARSER_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define NLP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("note line parser check failed");

// next-cycle implication, held off during reset
`define NLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("note line parser check failed");

`endif

// ===== rtl/nlp_pkg.sv =====
// ----------------------------------------------------------------------------
// nlp_pkg
// types and character codes shared by the note line parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nlp_pkg;

  localparam logic [7:0] CH_EQUAL = 8'h3d;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LOW_B = 8'h62;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_G  = 8'h47;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_G = 8'h67;

  localparam logic [2:0] ACC_NONE  = 3'd0;
  localparam logic [2:0] ACC_MINUS = 3'd1;
  localparam logic [2:0] ACC_PLUS  = 3'd2;
  localparam logic [2:0] ACC_FLAT  = 3'd3;
  localparam logic [2:0] ACC_SHARP = 3'd4;

  typedef enum logic [1:0] {
    KIND_NOTE  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [9:0] {
    PH_LINE_START = 10'b00_0000_0001,
    PH_COMMENT    = 10'b00_0000_0010,
    PH_ACC_OR_OCT = 10'b00_0000_0100,
    PH_OCTAVE     = 10'b00_0000_1000,
    PH_DASH       = 10'b00_0001_0000,
    PH_NUMER      = 10'b00_0010_0000,
    PH_AFTER_NUM  = 10'b00_0100_0000,
    PH_DENOM      = 10'b00_1000_0000,
    PH_AFTER_DEN  = 10'b01_0000_0000,
    PH_LF         = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [2:0] letter;
    logic [2:0] accidental;
    logic [3:0] octave;
    logic [3:0] numerator;
    logic [3:0] denominator;
  } held_t;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] letter;
    logic [2:0] accidental;
    logic [3:0] octave;
    logic [3:0] numerator;
    logic [3:0] denominator;
  } result_t;

endpackage

// ===== rtl/nlp_step.sv =====
// ----------------------------------------------------------------------------
// nlp_step
// one parser transition: phase and held fields in, next values and result out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlp_step (
  input  nlp_pkg::phase_t  phase,
  input  nlp_pkg::held_t   held,
  input  logic [7:0]       byte_value,
  input  logic             end_of_input,
  output nlp_pkg::phase_t  phase_next,
  output nlp_pkg::held_t   held_next,
  output logic             emit,
  output nlp_pkg::result_t result
);

  logic is_digit;
  logic is_denom;
  logic is_letter;
  logic note_done;
  logic fail;

  assign is_digit  = (byte_value >= nlp_pkg::CH_ZERO) && (byte_value <= nlp_pkg::CH_NINE);
  assign is_denom  = (byte_value >= nlp_pkg::CH_ONE) && (byte_value <= nlp_pkg::CH_NINE);
  assign is_letter = ((byte_value >= nlp_pkg::CH_UP_A) && (byte_value <= nlp_pkg::CH_UP_G)) ||
                     ((byte_value >= nlp_pkg::CH_LOW_A) && (byte_value <= nlp_pkg::CH_LOW_G));

  always_comb begin
    phase_next = phase;
    held_next  = held;
    note_done  = 1'b0;
    fail       = 1'b0;
    emit       = 1'b0;
    result     = '{kind: nlp_pkg::KIND_ERROR, letter: 3'd0, accidental: 3'd0,
                   octave: 4'd0, numerator: 4'd0, denominator: 4'd1};

    if (end_of_input) begin
      if (phase == nlp_pkg::PH_COMMENT || phase == nlp_pkg::PH_ACC_OR_OCT ||
          phase == nlp_pkg::PH_OCTAVE || phase == nlp_pkg::PH_DASH ||
          phase == nlp_pkg::PH_NUMER || phase == nlp_pkg::PH_AFTER_NUM ||
          phase == nlp_pkg::PH_DENOM || phase == nlp_pkg::PH_AFTER_DEN ||
          phase == nlp_pkg::PH_LF) begin
        fail = (phase != nlp_pkg::PH_COMMENT);
      end
      emit = 1'b1;
      if (!fail) begin
        result.kind = nlp_pkg::KIND_END;
      end
      phase_next = nlp_pkg::PH_LINE_START;
    end else begin
      unique case (phase)
        nlp_pkg::PH_COMMENT: begin
          if (byte_value == nlp_pkg::CH_LF) begin
            phase_next = nlp_pkg::PH_LINE_START;
          end
        end
        nlp_pkg::PH_ACC_OR_OCT: begin
          phase_next = nlp_pkg::PH_OCTAVE;
          if (is_digit) begin
            held_next.octave = byte_value[3:0];
            phase_next       = nlp_pkg::PH_DASH;
          end else if (byte_value == nlp_pkg::CH_SPACE) begin
            held_next.accidental = nlp_pkg::ACC_NONE;
          end else if (byte_value == nlp_pkg::CH_MINUS) begin
            held_next.accidental = nlp_pkg::ACC_MINUS;
          end else if (byte_value == nlp_pkg::CH_PLUS) begin
            held_next.accidental = nlp_pkg::ACC_PLUS;
          end else if (byte_value == nlp_pkg::CH_LOW_B) begin
            held_next.accidental = nlp_pkg::ACC_FLAT;
          end else if (byte_value == nlp_pkg::CH_HASH) begin
            held_next.accidental = nlp_pkg::ACC_SHARP;
          end else begin
            fail = 1'b1;
          end
        end
        nlp_pkg::PH_OCTAVE: begin
          held_next.octave = byte_value[3:0];
          phase_next       = nlp_pkg::PH_DASH;
          fail             = !is_digit;
        end
        nlp_pkg::PH_DASH: begin
          phase_next = nlp_pkg::PH_NUMER;
          fail       = (byte_value != nlp_pkg::CH_MINUS);
        end
        nlp_pkg::PH_NUMER: begin
          held_next.numerator = byte_value[3:0];
          phase_next          = nlp_pkg::PH_AFTER_NUM;
          fail                = !is_digit;
        end
        nlp_pkg::PH_AFTER_NUM: begin
          if (byte_value == nlp_pkg::CH_SLASH) begin
            phase_next = nlp_pkg::PH_DENOM;
          end else if (byte_value == nlp_pkg::CH_CR) begin
            phase_next = nlp_pkg::PH_LF;
          end else begin
            note_done = 1'b1;
          end
        end
        nlp_pkg::PH_DENOM: begin
          held_next.denominator = byte_value[3:0];
          phase_next            = nlp_pkg::PH_AFTER_DEN;
          fail                  = !is_denom;
        end
        nlp_pkg::PH_AFTER_DEN: begin
          if (byte_value == nlp_pkg::CH_CR) begin
            phase_next = nlp_pkg::PH_LF;
          end else begin
            note_done = 1'b1;
          end
        end
        nlp_pkg::PH_LF: begin
          note_done = 1'b1;
        end
        default: begin
          // line start, and any code with no meaning
          if (byte_value == nlp_pkg::CH_EQUAL) begin
            phase_next = nlp_pkg::PH_COMMENT;
          end else if (is_letter) begin
            // 'A'..'G' and 'a'..'g' share low bits 1..7
            held_next.letter      = byte_value[2:0] - 3'd1;
            held_next.accidental  = nlp_pkg::ACC_NONE;
            held_next.denominator = 4'd1;
            phase_next            = nlp_pkg::PH_ACC_OR_OCT;
          end else begin
            fail = 1'b1;
          end
        end
      endcase

      if (note_done) begin
        phase_next = nlp_pkg::PH_LINE_START;
        emit       = 1'b1;
        if (byte_value == nlp_pkg::CH_LF) begin
          result = '{kind: nlp_pkg::KIND_NOTE, letter: held.letter,
                     accidental: held.accidental, octave: held.octave,
                     numerator: held.numerator, denominator: held.denominator};
        end
      end

      if (fail) begin
        // held fields may change but are rewritten before the next note
        phase_next = nlp_pkg::PH_LINE_START;
        emit       = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/note_line_parser_core.sv =====
// ----------------------------------------------------------------------------
// note_line_parser_core
// byte-serial parser for note text lines
// ----------------------------------------------------------------------------
// Takes one byte word per clock while byte_stall is low, with no gaps needed
// between words. Each word is parsed in the cycle it is accepted; any result
// goes to the result register, or to the one skid entry if that register still
// holds an untaken result, so the byte side keeps flowing while a result
// waits; byte_stall rises only when both hold a result that is not yet taken.
// Bytes inside a comment or mid-line give no result; a finished line gives a
// note, a bad byte an error, and end of input an end or error result.
`timescale 1ns / 1ps
`include "note_line_parser_core_defines.svh"

module note_line_parser_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] byte_value,
  input  logic       end_of_input,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [1:0] result_kind,
  output logic [2:0] note_letter,
  output logic [2:0] accidental_code,
  output logic [3:0] octave_number,
  output logic [3:0] duration_numerator,
  output logic [3:0] duration_denominator
);

  nlp_pkg::phase_t  phase;
  nlp_pkg::phase_t  phase_next;
  nlp_pkg::held_t   held;
  nlp_pkg::held_t   held_next;
  nlp_pkg::result_t step_result;
  logic             step_emit;

  nlp_pkg::result_t out_res;
  nlp_pkg::result_t out_res_next;
  logic             out_valid_next;
  nlp_pkg::result_t skid_res;
  nlp_pkg::result_t skid_res_next;
  logic             skid_valid;
  logic             skid_valid_next;

  logic accept;
  logic pop;
  logic push;

  nlp_step u_step (
    .phase        (phase),
    .held         (held),
    .byte_value   (byte_value),
    .end_of_input (end_of_input),
    .phase_next   (phase_next),
    .held_next    (held_next),
    .emit         (step_emit),
    .result       (step_result)
  );

  assign byte_stall = skid_valid;
  assign accept     = byte_valid && !byte_stall;
  assign pop        = result_valid && !result_stall;
  assign push       = accept && step_emit;

  always_comb begin
    out_valid_next  = result_valid;
    out_res_next    = out_res;
    skid_valid_next = skid_valid;
    skid_res_next   = skid_res;
    if (pop) begin
      if (skid_valid) begin
        out_res_next    = skid_res;
        skid_valid_next = 1'b0;
      end else if (push) begin
        out_res_next = step_result;
      end else begin
        out_valid_next = 1'b0;
      end
    end else if (push) begin
      if (!result_valid) begin
        out_valid_next = 1'b1;
        out_res_next   = step_result;
      end else begin
        skid_valid_next = 1'b1;
        skid_res_next   = step_result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= nlp_pkg::PH_LINE_START;
      held         <= '{letter: 3'd0, accidental: 3'd0, octave: 4'd0,
                        numerator: 4'd1, denominator: 4'd1};
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase <= phase_next;
        held  <= held_next;
      end
      result_valid <= out_valid_next;
      skid_valid   <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_res  <= out_res_next;
    skid_res <= skid_res_next;
  end

  assign result_kind          = out_res.kind;
  assign note_letter          = out_res.letter;
  assign accidental_code      = out_res.accidental;
  assign octave_number        = out_res.octave;
  assign duration_numerator   = out_res.numerator;
  assign duration_denominator = out_res.denominator;

  `NLP_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, result_valid)
  `NLP_ASSERT_NEXT(a_skid_moves_up, clk, rst, skid_valid && !result_stall, result_valid)
  `NLP_ASSERT_NOW(a_plain_fields, clk, rst,
    result_valid && (result_kind != nlp_pkg::KIND_NOTE),
    (note_letter == 3'd0) && (duration_denominator == 4'd1))

endmodule
